### design/esd_pkg.sv
// Shared constants and types for the escape string decoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package esd_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned OutLenW       = 16;
  localparam int unsigned ResMax        = 3;

  localparam logic [7:0] EscByte = 8'h1B;
  localparam logic [7:0] BelByte = 8'h07;
  localparam logic [7:0] CrByte  = 8'h0D;
  localparam logic [7:0] DelByte = 8'h7F;

  // Results settled by one input character, handed from decoder to output stage.
  typedef struct packed {
    logic [ResMax-1:0][7:0] data;
    logic [1:0]             cnt;    // number of beats, 0 when nothing to send
    logic                   fin;    // group ends the string
    logic                   empty;  // string decoded to nothing on its final beat
    logic [OutLenW-1:0]     len;    // decoded byte count, meaningful with fin
  } grp_t;

endpackage

`default_nettype wire

### design/esd_decode.sv
// Decoder state and per-character logic: prefix, escape and append handling.
// Depends on esd_pkg; produces one result group per registered character.
`default_nettype none

module esd_decode #(
  parameter int unsigned LENGTH_BITS = esd_pkg::LengthBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic          advance_i,
  output esd_pkg::grp_t grp_o
);
  import esd_pkg::*;

  localparam int unsigned CntW = (LENGTH_BITS < OutLenW) ? LENGTH_BITS : OutLenW;

  localparam logic [7:0] Bslash = 8'h5C;
  localparam logic [7:0] Caret  = 8'h5E;

  typedef enum logic [2:0] {PhStart, PhSawM, PhSawDash, PhSkipWs, PhBody} phase_e;
  typedef enum logic [2:0] {EsNone, EsBslash, EsOct1, EsOct2, EsCaret} esc_e;
  typedef enum logic [1:0] {LdNone, LdEsc, LdOsc, LdOther} lead_e;

  typedef struct packed {
    logic [ResMax-1:0][7:0] data;
    logic [1:0]             cnt;
    logic [7:0]             prev;
    lead_e                  lead;
  } acc_t;

  phase_e          ph_q, ph_d;
  esc_e            es_q, es_d;
  logic [5:0]      oct_q, oct_d;
  logic [7:0]      prev_q;
  lead_e           lead_q;
  logic            app_q, app_d;
  logic [CntW-1:0] cnt_q, cnt_sat;
  logic [CntW:0]   cnt_sum;

  acc_t       acc;
  logic [1:0] n_emit;
  logic       do_body, do_plain, is_oct, is_space;
  logic [7:0] upc, kind;

  // Append one decoded byte and track the start of the output.
  function automatic acc_t push(acc_t a, logic [7:0] b);
    acc_t r;
    r = a;
    case (a.cnt)
      2'd0:    r.data[0] = b;
      2'd1:    r.data[1] = b;
      default: r.data[2] = b;
    endcase
    r.cnt  = a.cnt + 2'd1;
    r.prev = b;
    case (a.lead)
      LdNone:  r.lead = (b == EscByte) ? LdEsc : LdOther;
      LdEsc:   r.lead = (b == "]") ? LdOsc : LdOther;
      default: r.lead = a.lead;
    endcase
    return r;
  endfunction

  assign is_oct   = (byte_i >= "0") && (byte_i <= "7");
  assign is_space = (byte_i == " ") || ((byte_i >= 8'h09) && (byte_i <= 8'h0D));
  assign upc      = ((byte_i >= "a") && (byte_i <= "z")) ? (byte_i - 8'd32) : byte_i;

  always_comb begin
    acc      = '{data: '0, cnt: 2'd0, prev: prev_q, lead: lead_q};
    ph_d     = ph_q;
    es_d     = es_q;
    oct_d    = oct_q;
    app_d    = app_q;
    do_body  = 1'b0;
    do_plain = 1'b0;
    kind     = 8'h00;

    unique case (ph_q)
      PhStart: begin
        if (byte_i == "M") begin
          ph_d = PhSawM;
        end else begin
          ph_d    = PhBody;
          do_body = 1'b1;
        end
      end
      PhSawM: begin
        if (byte_i == "-") begin
          acc  = push(acc, EscByte);
          ph_d = PhSawDash;
        end else begin
          acc     = push(acc, "M");
          ph_d    = PhBody;
          do_body = 1'b1;
        end
      end
      PhSawDash: begin
        if (upc == "X") begin
          acc   = push(acc, "x");
          app_d = 1'b1;
          ph_d  = PhSkipWs;
        end else begin
          ph_d    = PhBody;
          do_body = 1'b1;
        end
      end
      PhSkipWs: begin
        if (!is_space) begin
          ph_d    = PhBody;
          do_body = 1'b1;
        end
      end
      default: begin
        ph_d    = PhBody;
        do_body = 1'b1;
      end
    endcase

    if (do_body) begin
      unique case (es_q)
        EsBslash: begin
          es_d = EsNone;
          if (is_oct) begin
            oct_d = {3'b000, byte_i[2:0]};
            es_d  = EsOct1;
          end else begin
            case (byte_i)
              "a":      acc = push(acc, BelByte);
              "b":      acc = push(acc, 8'h08);
              "E", "e": acc = push(acc, EscByte);
              "n":      acc = push(acc, 8'h0A);
              "r":      acc = push(acc, CrByte);
              "t":      acc = push(acc, 8'h09);
              default:  acc = push(acc, byte_i);
            endcase
          end
        end
        EsOct1: begin
          if (is_oct) begin
            oct_d = {oct_q[2:0], byte_i[2:0]};
            es_d  = EsOct2;
          end else begin
            es_d     = EsNone;
            acc      = push(acc, {2'b00, oct_q});
            do_plain = 1'b1;
          end
        end
        EsOct2: begin
          es_d = EsNone;
          if (is_oct) begin
            // third digit: value times eight plus digit, kept to a byte
            acc = push(acc, {oct_q[4:0], byte_i[2:0]});
          end else begin
            acc      = push(acc, {2'b00, oct_q});
            do_plain = 1'b1;
          end
        end
        EsCaret: begin
          es_d = EsNone;
          acc  = push(acc, (upc == "?") ? DelByte : (upc - 8'd64));
        end
        default: begin
          es_d     = EsNone;
          do_plain = 1'b1;
        end
      endcase
    end

    if (do_plain) begin
      if (byte_i == Bslash) begin
        es_d = EsBslash;
      end else if (byte_i == Caret) begin
        es_d = EsCaret;
      end else begin
        acc = push(acc, byte_i);
      end
    end

    if (last_i) begin
      if (ph_d == PhSawM) begin
        acc = push(acc, "M");
      end
      if ((es_d == EsOct1) || (es_d == EsOct2)) begin
        acc = push(acc, {2'b00, oct_d});
      end
      if (acc.lead == LdOsc) begin
        kind = BelByte;
      end else if (app_d) begin
        kind = CrByte;
      end
      if ((kind != 8'h00) && (acc.lead != LdNone) && (acc.prev != kind)) begin
        acc = push(acc, kind);
      end
    end
  end

  assign n_emit  = acc.cnt;
  assign cnt_sum = {1'b0, cnt_q} + (CntW + 1)'(n_emit);
  // Saturate: any carry out means the count passed all ones.
  assign cnt_sat = cnt_sum[CntW] ? {CntW{1'b1}} : cnt_sum[CntW-1:0];

  always_comb begin
    grp_o.data  = acc.data;
    grp_o.cnt   = acc.cnt;
    grp_o.fin   = last_i;
    grp_o.empty = 1'b0;
    grp_o.len   = OutLenW'(cnt_sat);
    if (last_i && (acc.cnt == 2'd0)) begin
      grp_o.data  = '0;
      grp_o.cnt   = 2'd1;
      grp_o.empty = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhStart;
      es_q   <= EsNone;
      oct_q  <= '0;
      prev_q <= '0;
      lead_q <= LdNone;
      app_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (advance_i) begin
      if (last_i) begin
        ph_q   <= PhStart;
        es_q   <= EsNone;
        oct_q  <= '0;
        prev_q <= '0;
        lead_q <= LdNone;
        app_q  <= 1'b0;
        cnt_q  <= '0;
      end else begin
        ph_q   <= ph_d;
        es_q   <= es_d;
        oct_q  <= oct_d;
        prev_q <= acc.prev;
        lead_q <= acc.lead;
        app_q  <= app_d;
        cnt_q  <= cnt_sat;
      end
    end
  end

endmodule

`default_nettype wire

### design/esd_outbuf.sv
// Result register: holds one group of up to three decoded bytes and sends them
// one beat at a time on the master stream. Depends on esd_pkg.
`default_nettype none

module esd_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  esd_pkg::grp_t grp_i,
  input  logic          load_i,
  output logic          free_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata,  // [7:0] out_byte, [23:8] out_length
  output logic          m_axis_tlast,  // out_last
  output logic          m_axis_tuser   // out_empty
);
  import esd_pkg::*;

  grp_t       grp_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       last_beat, beat;
  logic [7:0] cur_byte;

  assign last_beat = (idx_q == (grp_q.cnt - 2'd1));
  assign beat      = valid_q && m_axis_tready;
  assign free_o    = !valid_q || (m_axis_tready && last_beat);

  always_comb begin
    case (idx_q)
      2'd0:    cur_byte = grp_q.data[0];
      2'd1:    cur_byte = grp_q.data[1];
      default: cur_byte = grp_q.data[2];
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = grp_q.fin && last_beat;
  assign m_axis_tuser  = grp_q.empty;
  assign m_axis_tdata  = {(m_axis_tlast ? grp_q.len : {OutLenW{1'b0}}), cur_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (beat) begin
      if (last_beat) begin
        valid_q <= 1'b0;
        idx_q   <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Group payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

endmodule

`default_nettype wire

### design/escape_string_decoder_core.sv
// Escape string decoder: takes one string character per beat (tlast on the final
// one) and returns the decoded bytes, with the decoded length on the final beat.
// A character is taken every cycle as long as each one yields at most one byte
// and the master stream takes every beat; a character that settles more bytes
// (at most three) holds back the next character with output, since the result
// register sends one byte per beat. The first result of a character passes the
// input register, then the result register, before it is presented.
// A string that decodes to nothing ends with one beat flagged in tuser.
// Depends on esd_pkg, esd_decode and esd_outbuf.
`default_nettype none

module escape_string_decoder_core #(
  parameter int unsigned LENGTH_BITS = esd_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,  // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [23:8] out_length
  output logic        m_axis_tlast,  // out_last
  output logic        m_axis_tuser   // out_empty
);
  import esd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  grp_t       grp;
  logic       free, process, load;

  // Characters that produce nothing only update state and need no output slot.
  assign process       = in_valid_q && ((grp.cnt == 2'd0) || free);
  assign load          = process && (grp.cnt != 2'd0);
  assign s_axis_tready = !in_valid_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  esd_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .advance_i(process),
    .grp_o    (grp)
  );

  esd_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_i        (grp),
    .load_i       (load),
    .free_o       (free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'h00)))
    else $error("empty beat is not a zero final beat");

  a_len_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[23:8] == 16'h0000))
    else $error("length shown on a non-final beat");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> free)
    else $error("result group loaded over unsent beats");

  a_final_group_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_last_q) |=> m_axis_tvalid)
    else $error("final character left no result");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking bench for escape_string_decoder_core: sends escaped strings as beats and
// checks every decoded beat against an in-bench prediction of the decoder.
// Depends on esd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_top;
  import esd_pkg::*;

  localparam logic [OutLenW-1:0] LenSat =
    (LengthBitsDef >= OutLenW) ? '1 : OutLenW'((64'd1 << LengthBitsDef) - 1);

  localparam int LongLen = 64;

  localparam logic [7:0] ChM      = "M";
  localparam logic [7:0] ChDash   = "-";
  localparam logic [7:0] ChBslash = "\\";
  localparam logic [7:0] ChCaret  = "^";
  localparam logic [7:0] ChQuest  = "?";
  localparam logic [7:0] ChZero   = "0";
  localparam logic [7:0] ChSeven  = "7";
  localparam logic [7:0] ChUpX    = "X";
  localparam logic [7:0] ChLowX   = "x";
  localparam logic [7:0] ChLowA   = "a";
  localparam logic [7:0] ChRBrack = "]";
  localparam logic [7:0] BsByte   = 8'h08;
  localparam logic [7:0] LfByte   = 8'h0A;
  localparam logic [7:0] TabByte  = 8'h09;
  localparam logic [7:0] SpByte   = 8'h20;

  typedef enum logic [2:0] {PfxStart, PfxSawM, PfxSawDash, PfxSkipWs, PfxBody} pfx_e;
  typedef enum logic [2:0] {EscNone, EscSlash, EscOct1, EscOct2, EscCaret} esc_e;
  typedef enum logic [1:0] {LeadNone, LeadEsc, LeadOsc, LeadOther} lead_e;

  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    logic               empty;
    logic [OutLenW-1:0] len;
  } beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // decoder state as predicted
  pfx_e               pfx;
  esc_e               esc;
  logic [8:0]         oct_acc;
  logic [7:0]         prev_out;
  logic               cr_append;
  lead_e              lead;
  logic [OutLenW-1:0] out_count;

  logic [7:0] settled_q[$];
  beat_t      want_q[$];
  logic [7:0] str_q[$];

  int send_idle;
  int recv_idle;
  int err_count = 0;

  escape_string_decoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // generous cap: the slowest correct run stays far below this
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic is_oct(input logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == SpByte || (c >= TabByte && c <= CrByte);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  task automatic clear_decoder();
    pfx       = PfxStart;
    esc       = EscNone;
    oct_acc   = '0;
    prev_out  = '0;
    cr_append = 1'b0;
    lead      = LeadNone;
    out_count = '0;
  endtask

  task automatic put_byte(input int b);
    logic [7:0] v;
    v = b[7:0];
    settled_q.push_back(v);
    if (out_count < LenSat) out_count++;
    prev_out = v;
    case (lead)
      LeadNone: lead = (v == EscByte) ? LeadEsc : LeadOther;
      LeadEsc:  lead = (v == ChRBrack) ? LeadOsc : LeadOther;
      default: ;
    endcase
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == ChBslash) esc = EscSlash;
    else if (c == ChCaret) esc = EscCaret;
    else put_byte(c);
  endtask

  task automatic body_char(input logic [7:0] c);
    logic [7:0] up;
    case (esc)
      EscSlash: begin
        esc = EscNone;
        if (is_oct(c)) begin
          oct_acc = 9'(c - ChZero);
          esc = EscOct1;
        end else begin
          case (c)
            "a":      put_byte(BelByte);
            "b":      put_byte(BsByte);
            "E", "e": put_byte(EscByte);
            "n":      put_byte(LfByte);
            "r":      put_byte(CrByte);
            "t":      put_byte(TabByte);
            default:  put_byte(c);
          endcase
        end
      end
      EscOct1: begin
        if (is_oct(c)) begin
          oct_acc = 9'(oct_acc * 8 + (c - ChZero));
          esc = EscOct2;
        end else begin
          esc = EscNone;
          put_byte(oct_acc);
          plain_char(c);
        end
      end
      EscOct2: begin
        esc = EscNone;
        if (is_oct(c)) begin
          put_byte(oct_acc * 8 + (c - ChZero));
        end else begin
          put_byte(oct_acc);
          plain_char(c);
        end
      end
      EscCaret: begin
        esc = EscNone;
        up = upcase(c);
        put_byte(up == ChQuest ? DelByte : up - 8'd64);
      end
      default: plain_char(c);
    endcase
  endtask

  // Work out the beats that one accepted character settles and queue them.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [7:0] tail;
    settled_q.delete();
    case (pfx)
      PfxStart: begin
        if (c == ChM) begin
          pfx = PfxSawM;
        end else begin
          pfx = PfxBody;
          body_char(c);
        end
      end
      PfxSawM: begin
        if (c == ChDash) begin
          put_byte(EscByte);
          pfx = PfxSawDash;
        end else begin
          put_byte(ChM);
          pfx = PfxBody;
          body_char(c);
        end
      end
      PfxSawDash: begin
        if (upcase(c) == ChUpX) begin
          put_byte(ChLowX);
          cr_append = 1'b1;
          pfx = PfxSkipWs;
        end else begin
          pfx = PfxBody;
          body_char(c);
        end
      end
      PfxSkipWs: begin
        if (!is_ws(c)) begin
          pfx = PfxBody;
          body_char(c);
        end
      end
      default: body_char(c);
    endcase

    if (!last) begin
      foreach (settled_q[i]) want_q.push_back('{settled_q[i], 1'b0, 1'b0, '0});
      return;
    end

    if (pfx == PfxSawM) put_byte(ChM);
    if (esc == EscOct1 || esc == EscOct2) put_byte(oct_acc);
    tail = '0;
    if (cr_append) tail = CrByte;
    if (lead == LeadOsc) tail = BelByte;
    if (tail != '0 && lead != LeadNone && prev_out != tail) put_byte(tail);

    if (settled_q.size() == 0) begin
      want_q.push_back('{8'h00, 1'b1, 1'b1, out_count});
    end else begin
      foreach (settled_q[i]) begin
        if (i == settled_q.size() - 1) want_q.push_back('{settled_q[i], 1'b1, 1'b0, out_count});
        else want_q.push_back('{settled_q[i], 1'b0, 1'b0, '0});
      end
    end
    clear_decoder();
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_char(c, last);
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (str_q[i]) send_char(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    send_line();
  endtask

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_beat();
    beat_t              want;
    logic [7:0]         got_byte;
    logic [OutLenW-1:0] got_len;
    got_byte = m_axis_tdata[7:0];
    got_len  = m_axis_tdata[23:8];
    if (want_q.size() == 0) begin
      report_error($sformatf("unexpected beat: byte %h last %b empty %b len %0d",
                             got_byte, m_axis_tlast, m_axis_tuser, got_len));
    end else begin
      want = want_q.pop_front();
      // byte carries nothing on an empty beat
      if ((!want.empty && got_byte != want.data) || m_axis_tlast != want.last ||
          m_axis_tuser != want.empty || got_len != want.len)
        report_error($sformatf({"mismatch: expected byte %h last %b empty %b len %0d,",
                                " got byte %h last %b empty %b len %0d"},
                               want.data, want.last, want.empty, want.len,
                               got_byte, m_axis_tlast, m_axis_tuser, got_len));
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat();
  end

  task automatic test_lone_markers();
    send_text("M");
    send_text("^");
    send_text("\\");
  endtask

  task automatic test_meta_prefix();
    send_text("M-X \015");
    send_text("M-x\\r");
  endtask

  task automatic test_osc_bel();
    send_text("\\e]\\777");
  endtask

  task automatic test_controls_and_extremes();
    send_text("^?^a\\1");
    send_text("\001\377");
  endtask

  // Mostly well-formed escapes with random content, plus raw noise bytes.
  task automatic test_random_strings(input int n_items);
    int    sent;
    int    ntok;
    string letters;
    sent = 0;
    letters = "abEenrtq";
    while (sent < n_items) begin
      str_q.delete();
      case ($urandom_range(7))
        0, 1: begin
          str_q.push_back(ChM);
          str_q.push_back(ChDash);
          if ($urandom_range(3) != 0) str_q.push_back($urandom_range(1) ? ChLowX : ChUpX);
          repeat ($urandom_range(2))
            str_q.push_back($urandom_range(5) == 0 ? SpByte : 8'($urandom_range(9, 13)));
        end
        2: begin
          if ($urandom_range(1)) begin
            str_q.push_back(ChBslash);
            str_q.push_back("e");
          end else begin
            str_q.push_back(ChCaret);
            str_q.push_back("[");
          end
          str_q.push_back(ChRBrack);
        end
        3: str_q.push_back(ChM);
        default: ;
      endcase
      ntok = $urandom_range(1, 6);
      repeat (ntok) begin
        case ($urandom_range(9))
          0, 1, 2: str_q.push_back(8'($urandom_range(1, 255)));
          3: begin
            str_q.push_back(ChBslash);
            str_q.push_back(letters[$urandom_range(7)]);
          end
          4: begin
            str_q.push_back(ChBslash);
            repeat ($urandom_range(1, 3)) str_q.push_back(ChZero + 8'($urandom_range(7)));
          end
          5: begin
            str_q.push_back(ChCaret);
            str_q.push_back(8'($urandom_range(1, 255)));
          end
          6: begin
            str_q.push_back(ChCaret);
            str_q.push_back(ChQuest);
          end
          7: str_q.push_back($urandom_range(3) == 0 ? SpByte : 8'($urandom_range(9, 13)));
          default: str_q.push_back(8'($urandom_range(32, 126)));
        endcase
      end
      // end on an unfinished escape or on a terminator now and then
      case ($urandom_range(6))
        0: str_q.push_back(ChBslash);
        1: str_q.push_back(ChCaret);
        2: begin
          str_q.push_back(ChBslash);
          repeat ($urandom_range(1, 2)) str_q.push_back(ChZero + 8'($urandom_range(7)));
        end
        3: str_q.push_back(CrByte);
        4: begin
          str_q.push_back(ChBslash);
          str_q.push_back("a");
        end
        default: ;
      endcase
      send_line();
      sent += str_q.size();
    end
  endtask

  // One long plain string: the decoded length climbs over many beats.
  task automatic test_long_string();
    for (int i = 0; i < LongLen; i++) send_char(ChLowA, i == LongLen - 1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    send_idle     = 12;
    recv_idle     = 56;
    clear_decoder();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_lone_markers();
    test_meta_prefix();
    test_osc_bel();
    test_controls_and_extremes();
    test_random_strings(140);
    send_idle = 56;
    recv_idle = 12;
    test_random_strings(140);
    send_idle = 0;
    recv_idle = 0;
    test_random_strings(140);
    test_long_string();

    s_axis_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
